// ----- rtl/ltok_pkg.sv -----
// Shared types, codes and the token classifier of the line tokeniser.
package ltok_pkg;

	// Kept head bytes of a pending token, and the depth of the job queue.
	localparam int HEAD_DEPTH = 5;
	localparam int JOB_DEPTH  = 4;

	// Character codes with a meaning of their own.
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Token type codes.
	localparam logic [4:0] TT_IDENT   = 5'd0;
	localparam logic [4:0] TT_NUMBER  = 5'd1;
	localparam logic [4:0] TT_STRING  = 5'd2;
	localparam logic [4:0] TT_PLUS    = 5'd3;
	localparam logic [4:0] TT_MINUS   = 5'd4;
	localparam logic [4:0] TT_STAR    = 5'd5;
	localparam logic [4:0] TT_SLASH   = 5'd6;
	localparam logic [4:0] TT_DSLASH  = 5'd7;
	localparam logic [4:0] TT_ASSIGN  = 5'd8;
	localparam logic [4:0] TT_GT      = 5'd9;
	localparam logic [4:0] TT_LT      = 5'd10;
	localparam logic [4:0] TT_EQ      = 5'd11;
	localparam logic [4:0] TT_NE      = 5'd12;
	localparam logic [4:0] TT_GE      = 5'd13;
	localparam logic [4:0] TT_LE      = 5'd14;
	localparam logic [4:0] TT_AND     = 5'd15;
	localparam logic [4:0] TT_OR      = 5'd16;
	localparam logic [4:0] TT_NOT     = 5'd17;
	localparam logic [4:0] TT_PRINT   = 5'd18;
	localparam logic [4:0] TT_IF      = 5'd19;
	localparam logic [4:0] TT_ELSE    = 5'd20;
	localparam logic [4:0] TT_WHILE   = 5'd21;
	localparam logic [4:0] TT_ELIF    = 5'd22;
	localparam logic [4:0] TT_COMMA   = 5'd23;
	localparam logic [4:0] TT_COLON   = 5'd24;
	localparam logic [4:0] TT_LPAR    = 5'd25;
	localparam logic [4:0] TT_RPAR    = 5'd26;
	localparam logic [4:0] TT_LBRACK  = 5'd27;
	localparam logic [4:0] TT_RBRACK  = 5'd28;
	localparam logic [4:0] TT_UNKNOWN = 5'd29;

	// Error codes.
	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN = 2'd1;
	localparam logic [1:0] ERR_LONG    = 2'd2;

	// Result kinds.
	localparam logic KIND_TOKEN = 1'b0;
	localparam logic KIND_EOL   = 1'b1;

	// Scanner mode.
	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_STRING  = 2'd1,
		MODE_COMMENT = 2'd2
	} scan_mode_t;

	typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

	// One input item.
	typedef struct packed {
		logic [7:0] char_code;
		logic       line_end;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic        item_kind;
		logic [4:0]  token_type;
		logic [11:0] start_column;
		logic [5:0]  token_length;
		logic [1:0]  error_code;
		logic        is_last;
	} out_item_t;

	// A token as captured by the front end, not yet classified.
	typedef struct packed {
		head_t       head;
		logic [5:0]  len;
		logic [11:0] start;
		logic [7:0]  last;
		logic        ovf;
	} tok_t;

	// Work for the back end: an optional flushed token, then an optional
	// single-character token or end-of-line marker.
	typedef struct packed {
		logic a_vld;
		tok_t a;
		logic b_vld;
		logic b_kind;
		tok_t b;
	} job_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// Classifies a token from its length, its kept head and its last byte.
	// Head bytes past the length are always zero, so the fixed words can be
	// matched on the whole head; head byte 0 sits in the low bits, hence the
	// reversed spelling of each word.
	function automatic logic [4:0] classify(input head_t head, input logic [5:0] len,
			input logic [7:0] last);
		logic [4:0] ty;
		unique case ({len, head})
			{6'd2, 24'h0, "fi"}:    ty = TT_IF;
			{6'd4, 8'h0, "esle"}:   ty = TT_ELSE;
			{6'd5, "elihw"}:        ty = TT_WHILE;
			{6'd4, 8'h0, "file"}:   ty = TT_ELIF;
			{6'd5, "tnirp"}:        ty = TT_PRINT;
			{6'd1, 32'h0, "+"}:     ty = TT_PLUS;
			{6'd1, 32'h0, "-"}:     ty = TT_MINUS;
			{6'd1, 32'h0, "*"}:     ty = TT_STAR;
			{6'd1, 32'h0, "/"}:     ty = TT_SLASH;
			{6'd2, 24'h0, "//"}:    ty = TT_DSLASH;
			{6'd1, 32'h0, "="}:     ty = TT_ASSIGN;
			{6'd1, 32'h0, ">"}:     ty = TT_GT;
			{6'd1, 32'h0, "<"}:     ty = TT_LT;
			{6'd2, 24'h0, "=="}:    ty = TT_EQ;
			{6'd2, 24'h0, "=!"}:    ty = TT_NE;
			{6'd2, 24'h0, "=>"}:    ty = TT_GE;
			{6'd2, 24'h0, "=<"}:    ty = TT_LE;
			{6'd3, 16'h0, "dna"}:   ty = TT_AND;
			{6'd2, 24'h0, "ro"}:    ty = TT_OR;
			{6'd3, 16'h0, "ton"}:   ty = TT_NOT;
			{6'd1, 32'h0, ","}:     ty = TT_COMMA;
			{6'd1, 32'h0, ":"}:     ty = TT_COLON;
			{6'd1, 32'h0, "("}:     ty = TT_LPAR;
			{6'd1, 32'h0, ")"}:     ty = TT_RPAR;
			{6'd1, 32'h0, "["}:     ty = TT_LBRACK;
			{6'd1, 32'h0, "]"}:     ty = TT_RBRACK;
			default: begin
				if (is_letter(head[0])) begin
					ty = TT_IDENT;
				end else if (is_digit(head[0])) begin
					ty = TT_NUMBER;
				end else if (head[0] == CH_QUOTE && last == CH_QUOTE) begin
					ty = TT_STRING;
				end else begin
					ty = TT_UNKNOWN;
				end
			end
		endcase
		return ty;
	endfunction

endpackage

// ----- rtl/line_tokenizer.sv -----
// Top level of the line tokeniser: front end, job queue and back end.
//
// The block takes one character of a source line per transfer and returns the
// classified tokens, then an end-of-line marker when line_end is given. It
// accepts a character in every cycle; the back end hands out one result per
// cycle while results are taken, so a character that completes two results
// (a pending token followed by punctuation or by the end-of-line marker)
// holds the back end for both of them. A queue of four jobs between front and
// back absorbs these, and input is held off by full only when that queue
// fills. A token passes through the job queue and then the output register,
// entering the latter when it is free. No memory needs clearing after reset.
module line_tokenizer #(
	parameter int MAX_TOKEN_CHARS = 64,
	parameter int MAX_LINE_CHARS  = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  ltok_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output ltok_pkg::out_item_t result
);
	import ltok_pkg::*;

	job_t job_in;
	job_t job_out;
	logic job_push;
	logic job_full;
	logic job_pop;
	logic job_empty;

	// Character scanning.
	ltok_front #(
		.MAX_TOKEN_CHARS(MAX_TOKEN_CHARS),
		.MAX_LINE_CHARS (MAX_LINE_CHARS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.job_full(job_full),
		.job_push(job_push),
		.job     (job_in)
	);

	// Decoupling queue.
	ltok_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_data(job_in),
		.full     (job_full),
		.pop      (job_pop),
		.pop_data (job_out),
		.empty    (job_empty)
	);

	// Classification and result output.
	ltok_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job      (job_out),
		.job_pop  (job_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

// ----- rtl/ltok_fifo.sv -----
// Short job queue between the scanning front end and the result back end.
module ltok_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ltok_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output ltok_pkg::job_t pop_data,
	output logic          empty
);
	import ltok_pkg::*;

	localparam int PtrW = $clog2(JOB_DEPTH);
	localparam int CntW = $clog2(JOB_DEPTH + 1);

	job_t            mem_q [JOB_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = count_q == CntW'(JOB_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/ltok_front.sv -----
// Front end: takes one character per transfer, tracks the pending token and
// the scan mode, and queues the tokens that each character completes.
module ltok_front #(
	parameter int MAX_TOKEN_CHARS = 64,
	parameter int MAX_LINE_CHARS  = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  ltok_pkg::in_item_t item,
	input  logic               job_full,
	output logic               job_push,
	output ltok_pkg::job_t     job
);
	import ltok_pkg::*;

	localparam int LenCap = (MAX_TOKEN_CHARS - 1 > 63) ? 63 : MAX_TOKEN_CHARS - 1;
	localparam int ColMax = (MAX_LINE_CHARS > 4096 ? 4096 : MAX_LINE_CHARS) - 1;

	scan_mode_t  mode_q, mode_d;
	tok_t        pend_q, pend_d;
	logic [11:0] col_q, col_d;
	tok_t        app;
	tok_t        cleared;
	tok_t        single;
	logic        accept;
	logic [7:0]  c;
	logic        has_pend;

	assign full     = job_full;
	assign accept   = push && !job_full;
	assign c        = item.char_code;
	assign has_pend = pend_q.len != '0;

	// Pending token with the current character appended.
	always_comb begin
		app = pend_q;
		if (!has_pend) begin
			app.start = col_q;
			app.ovf   = 1'b0;
		end
		if (pend_q.len < 6'(LenCap)) begin
			if (pend_q.len < 6'(HEAD_DEPTH)) begin
				app.head[pend_q.len[2:0]] = c;
			end
			app.len = pend_q.len + 1'b1;
		end else begin
			app.ovf = 1'b1;
		end
		app.last = c;
	end

	// Empty pending token, keeping its start column, and the one-character
	// token that a punctuation character makes.
	always_comb begin
		cleared       = '0;
		cleared.start = pend_q.start;
		single        = '0;
		single.head[0] = c;
		single.len    = 6'd1;
		single.start  = col_q;
		single.last   = c;
	end

	// Scanner decisions for one character or line end.
	always_comb begin
		mode_d     = mode_q;
		pend_d     = pend_q;
		col_d      = col_q;
		job        = '0;
		job.a      = pend_q;
		job.b      = single;
		job.b_kind = KIND_TOKEN;
		if (item.line_end) begin
			job.a_vld   = has_pend;
			job.b_vld   = 1'b1;
			job.b_kind  = KIND_EOL;
			job.b       = '0;
			job.b.start = col_q;
			mode_d      = MODE_NORMAL;
			col_d       = '0;
			pend_d      = '0;
		end else begin
			if (col_q < 12'(ColMax)) begin
				col_d = col_q + 1'b1;
			end
			if (mode_q == MODE_NORMAL || mode_q == MODE_STRING) begin
				if (c == CH_HASH) begin
					mode_d = MODE_COMMENT;
				end else if (mode_q == MODE_STRING) begin
					if (c == CH_QUOTE) begin
						job.a_vld = 1'b1;
						job.a     = app;
						pend_d    = cleared;
						pend_d.start = app.start;
						mode_d    = MODE_NORMAL;
					end else begin
						pend_d = app;
					end
				end else if (is_space(c)) begin
					job.a_vld = has_pend;
					pend_d    = cleared;
				end else if (c == CH_LPAR || c == CH_RPAR || c == CH_COLON || c == CH_COMMA) begin
					job.a_vld = has_pend;
					job.b_vld = 1'b1;
					pend_d    = cleared;
				end else if (c == CH_QUOTE) begin
					pend_d = app;
					mode_d = MODE_STRING;
				end else begin
					pend_d = app;
				end
			end else begin
				mode_d = MODE_COMMENT;
			end
		end
	end

	assign job_push = accept && (job.a_vld || job.b_vld);

	// Scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			pend_q <= '0;
			col_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			col_q  <= col_d;
		end
	end

endmodule

// ----- rtl/ltok_back.sv -----
// Back end: classifies queued tokens and hands results out one per transfer
// through an output register.
module ltok_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_empty,
	input  ltok_pkg::job_t      job,
	output logic                job_pop,
	output logic                empty,
	input  logic                pop,
	output ltok_pkg::out_item_t result
);
	import ltok_pkg::*;

	logic      phase_q;
	logic      res_vld_q;
	out_item_t res_q;
	out_item_t res_d;
	logic      emit_a;
	logic      done_job;
	logic      load;
	tok_t      tok;
	logic [4:0] ty;

	assign emit_a   = job.a_vld && !phase_q;
	assign done_job = emit_a ? !job.b_vld : 1'b1;
	assign load     = !job_empty && (!res_vld_q || pop);
	assign job_pop  = load && done_job;
	assign empty    = !res_vld_q;
	assign result   = res_q;

	// Pick the token of this job that goes out next and classify it.
	always_comb begin
		tok = emit_a ? job.a : job.b;
		ty  = classify(tok.head, tok.len, tok.last);
		res_d              = '0;
		res_d.item_kind    = emit_a ? KIND_TOKEN : job.b_kind;
		res_d.is_last      = done_job;
		res_d.start_column = tok.start;
		if (res_d.item_kind == KIND_TOKEN) begin
			res_d.token_type   = ty;
			res_d.token_length = tok.len;
			if (tok.ovf) begin
				res_d.error_code = ERR_LONG;
			end else if (ty == TT_UNKNOWN) begin
				res_d.error_code = ERR_UNKNOWN;
			end else begin
				res_d.error_code = ERR_OK;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	// Result valid and position within a two-result job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			phase_q   <= 1'b0;
		end else begin
			if (load) begin
				res_vld_q <= 1'b1;
				phase_q   <= !done_job;
			end else if (pop) begin
				res_vld_q <= 1'b0;
			end
		end
	end

endmodule

// ----- tb/sv/tb_line_tokenizer.sv -----
// Self-checking testbench of the line tokeniser: stimulus, prediction and result checking.
module tb_line_tokenizer;
	import ltok_pkg::*;

	// Token length cap and column ceiling at the default parameters.
	localparam int LEN_CAP = 63;
	localparam int COL_MAX = 4095;

	typedef logic [0:4][7:0] head5_t;

	// One character waiting to be sent, with a request to let results drain first.
	typedef struct {
		in_item_t it;
		bit       drain;
	} feed_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	logic      full;
	logic      empty;
	in_item_t  item   = '0;
	out_item_t result;

	feed_t     char_feed[$];
	out_item_t expected_tokens[$];
	out_item_t want;

	// Predictor state of the scanner.
	scan_mode_t  lx_mode;
	logic [5:0]  pend_len;
	logic [11:0] pend_start;
	logic [11:0] col;
	head5_t      pend_head;
	logic [7:0]  pend_last;
	bit          pend_ovf;

	// Stimulus generation flags and run statistics.
	bit hold_next = 0;
	int stim_count = 0;
	int chars_sent = 0;
	int lines_sent = 0;
	int n_tokens = 0, n_markers = 0, n_long = 0, n_unknown = 0, n_strings = 0;
	int n_checked = 0;
	int fail_count = 0;

	// Sender and receiver pacing.
	int burst_left = 0;
	int gap_left   = 0;
	int stall_left = 0;
	int stall_style = 0;
	int cyc = 0;

	string fixed_words[26] = '{"if", "else", "while", "elif", "print", "+", "-", "*", "/",
		"//", "=", ">", "<", "==", "!=", ">=", "<=", "and", "or", "not", ",", ":", "(",
		")", "[", "]"};
	string odd_chars = "@$?~.!&%^|;{}`'\\";

	line_tokenizer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #4 clk = ~clk;

	// Character classes of the scanner.
	function automatic bit alpha_ch(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit digit_ch(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit blank_ch(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// Token type from the length, the first five kept bytes and the last byte received.
	// Bytes past the length are zero, so fixed words are matched on the whole head.
	function automatic logic [4:0] token_class(input logic [5:0] len, input head5_t h,
			input logic [7:0] last);
		logic [4:0] t;
		case ({len, h})
			{6'd2, "if", 24'h0}:    t = TT_IF;
			{6'd4, "else", 8'h0}:   t = TT_ELSE;
			{6'd5, "while"}:        t = TT_WHILE;
			{6'd4, "elif", 8'h0}:   t = TT_ELIF;
			{6'd5, "print"}:        t = TT_PRINT;
			{6'd1, "+", 32'h0}:     t = TT_PLUS;
			{6'd1, "-", 32'h0}:     t = TT_MINUS;
			{6'd1, "*", 32'h0}:     t = TT_STAR;
			{6'd1, "/", 32'h0}:     t = TT_SLASH;
			{6'd2, "//", 24'h0}:    t = TT_DSLASH;
			{6'd1, "=", 32'h0}:     t = TT_ASSIGN;
			{6'd1, ">", 32'h0}:     t = TT_GT;
			{6'd1, "<", 32'h0}:     t = TT_LT;
			{6'd2, "==", 24'h0}:    t = TT_EQ;
			{6'd2, "!=", 24'h0}:    t = TT_NE;
			{6'd2, ">=", 24'h0}:    t = TT_GE;
			{6'd2, "<=", 24'h0}:    t = TT_LE;
			{6'd3, "and", 16'h0}:   t = TT_AND;
			{6'd2, "or", 24'h0}:    t = TT_OR;
			{6'd3, "not", 16'h0}:   t = TT_NOT;
			{6'd1, ",", 32'h0}:     t = TT_COMMA;
			{6'd1, ":", 32'h0}:     t = TT_COLON;
			{6'd1, "(", 32'h0}:     t = TT_LPAR;
			{6'd1, ")", 32'h0}:     t = TT_RPAR;
			{6'd1, "[", 32'h0}:     t = TT_LBRACK;
			{6'd1, "]", 32'h0}:     t = TT_RBRACK;
			default: begin
				if (alpha_ch(h[0])) begin
					t = TT_IDENT;
				end else if (digit_ch(h[0])) begin
					t = TT_NUMBER;
				end else if (h[0] == CH_QUOTE && last == CH_QUOTE) begin
					t = TT_STRING;
				end else begin
					t = TT_UNKNOWN;
				end
			end
		endcase
		return t;
	endfunction

	function automatic out_item_t mk_result(input logic kind, input logic [4:0] ty,
			input logic [11:0] start, input logic [5:0] len, input logic [1:0] err);
		out_item_t r;
		r.item_kind    = kind;
		r.token_type   = ty;
		r.start_column = start;
		r.token_length = len;
		r.error_code   = err;
		r.is_last      = 1'b0;
		return r;
	endfunction

	// Empties the pending token.
	function automatic void clear_pending();
		pend_len  = '0;
		pend_ovf  = 0;
		pend_head = '0;
		pend_last = '0;
	endfunction

	// Classifies the pending token, clears it and returns its result.
	function automatic out_item_t flush_token();
		logic [4:0] t;
		logic [1:0] e;
		t = token_class(pend_len, pend_head, pend_last);
		e = pend_ovf ? ERR_LONG : (t == TT_UNKNOWN ? ERR_UNKNOWN : ERR_OK);
		n_tokens++;
		if (pend_ovf) n_long++;
		if (t == TT_UNKNOWN) n_unknown++;
		if (t == TT_STRING) n_strings++;
		flush_token = mk_result(KIND_TOKEN, t, pend_start, pend_len, e);
		clear_pending();
	endfunction

	// Adds a byte to the pending token; bytes past the cap only mark the overflow.
	task automatic add_char(input logic [7:0] c);
		if (pend_len == 0) begin
			pend_start = col;
			pend_ovf   = 0;
		end
		if (pend_len < LEN_CAP) begin
			if (pend_len < 5) pend_head[pend_len[2:0]] = c;
			pend_len++;
		end else begin
			pend_ovf = 1;
		end
		pend_last = c;
	endtask

	task automatic reset_scanner();
		lx_mode    = MODE_NORMAL;
		pend_start = '0;
		col        = '0;
		clear_pending();
	endtask

	// Works out the results that one transferred character causes and queues them.
	task automatic tokenize_char(input in_item_t it);
		out_item_t outs[2];
		int n;
		logic [7:0] c;
		head5_t one;
		logic [4:0] t;
		n = 0;
		c = it.char_code;
		if (it.line_end) begin
			if (pend_len > 0) begin
				outs[n] = flush_token();
				n++;
			end
			outs[n] = mk_result(KIND_EOL, '0, col, '0, ERR_OK);
			n++;
			n_markers++;
			reset_scanner();
		end else begin
			if (lx_mode == MODE_COMMENT) begin
				// The rest of the line is ignored.
			end else if (c == CH_HASH) begin
				lx_mode = MODE_COMMENT;
			end else if (lx_mode == MODE_STRING) begin
				add_char(c);
				if (c == CH_QUOTE) begin
					outs[n] = flush_token();
					n++;
					lx_mode = MODE_NORMAL;
				end
			end else if (blank_ch(c)) begin
				if (pend_len > 0) begin
					outs[n] = flush_token();
					n++;
				end
			end else if (c == CH_LPAR || c == CH_RPAR || c == CH_COLON || c == CH_COMMA) begin
				if (pend_len > 0) begin
					outs[n] = flush_token();
					n++;
				end
				one    = '0;
				one[0] = c;
				t = token_class(6'd1, one, c);
				outs[n] = mk_result(KIND_TOKEN, t, col, 6'd1,
					t == TT_UNKNOWN ? ERR_UNKNOWN : ERR_OK);
				n++;
				n_tokens++;
			end else if (c == CH_QUOTE) begin
				add_char(c);
				lx_mode = MODE_STRING;
			end else begin
				add_char(c);
			end
			if (col < COL_MAX) col++;
		end
		if (n > 0) outs[n-1].is_last = 1'b1;
		for (int i = 0; i < n; i++) expected_tokens.push_back(outs[i]);
	endtask

	task automatic report_fail(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
	endtask

	// Stimulus helpers.
	task automatic put_item(input logic [7:0] c, input logic le);
		feed_t f;
		f.it.char_code = c;
		f.it.line_end  = le;
		f.drain        = hold_next;
		hold_next      = 0;
		char_feed.push_back(f);
		stim_count++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) put_item(s[i], 1'b0);
	endtask

	task automatic put_eol();
		put_item(8'($urandom_range(1, 255)), 1'b1);
	endtask

	function automatic logic [7:0] rand_alnum();
		case ($urandom_range(0, 2))
			0: return 8'(8'h61 + $urandom_range(0, 25));
			1: return 8'(8'h41 + $urandom_range(0, 25));
			default: return 8'(8'h30 + $urandom_range(0, 9));
		endcase
	endfunction

	// A byte for the body of a string: printable, no quote, now and then a high byte.
	function automatic logic [7:0] rand_text_char();
		logic [7:0] c;
		if ($urandom_range(0, 15) == 0) return 8'($urandom_range(128, 255));
		c = 8'($urandom_range(32, 126));
		while (c == CH_QUOTE || c == CH_HASH) c = 8'($urandom_range(32, 126));
		return c;
	endfunction

	// Emits one token of a random kind, without separators.
	task automatic put_token();
		int k;
		int len;
		k = $urandom_range(0, 19);
		case (k)
			5, 6: begin
				put_item(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
				len = $urandom_range(0, 7);
				for (int i = 0; i < len; i++)
					put_item($urandom_range(0, 5) == 0 ? 8'h5F : rand_alnum(), 1'b0);
			end
			7: begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					put_item(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
				if ($urandom_range(0, 3) == 0) put_item(rand_alnum(), 1'b0);
			end
			8: begin
				put_item(CH_QUOTE, 1'b0);
				len = $urandom_range(0, 10);
				for (int i = 0; i < len; i++) put_item(rand_text_char(), 1'b0);
				put_item(CH_QUOTE, 1'b0);
			end
			9: begin
				case ($urandom_range(0, 3))
					0: put_item(CH_LPAR, 1'b0);
					1: put_item(CH_RPAR, 1'b0);
					2: put_item(CH_COLON, 1'b0);
					default: put_item(CH_COMMA, 1'b0);
				endcase
			end
			10: begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 2) == 0) put_item(8'($urandom_range(128, 255)), 1'b0);
					else put_item(odd_chars[$urandom_range(0, odd_chars.len() - 1)], 1'b0);
				end
			end
			11: begin
				// Overlong token around the length cap; sometimes a long string.
				len = $urandom_range(58, 72);
				if ($urandom_range(0, 2) == 0) begin
					put_item(CH_QUOTE, 1'b0);
					for (int i = 0; i < len; i++) put_item(rand_text_char(), 1'b0);
					put_item(CH_QUOTE, 1'b0);
				end else begin
					for (int i = 0; i < len; i++) put_item(rand_alnum(), 1'b0);
				end
			end
			12: begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++) put_item(8'($urandom_range(1, 255)), 1'b0);
			end
			default: put_text(fixed_words[$urandom_range(0, 25)]);
		endcase
	endtask

	// One line: mostly well-formed token sequences, sometimes pure noise.
	task automatic make_line();
		int n;
		int k;
		if ($urandom_range(0, 24) == 0) hold_next = 1;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 20);
			for (int i = 0; i < n; i++) put_item(8'($urandom_range(1, 255)), 1'b0);
		end else begin
			n = $urandom_range(0, 8);
			for (int i = 0; i < n; i++) begin
				k = $urandom_range(0, 5);
				if (k == 4) put_item(8'($urandom_range(9, 13)), 1'b0);
				else if (k == 5) put_text("  ");
				else if (k != 0) put_item(CH_SPACE, 1'b0);
				put_token();
			end
			// Unterminated string running into the end of the line.
			if ($urandom_range(0, 14) == 0) begin
				put_item(CH_QUOTE, 1'b0);
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++) put_item(rand_text_char(), 1'b0);
			end
			if ($urandom_range(0, 5) == 0) begin
				put_item(CH_HASH, 1'b0);
				n = $urandom_range(0, 10);
				for (int i = 0; i < n; i++) put_item(8'($urandom_range(1, 255)), 1'b0);
			end
		end
		put_eol();
	endtask

	// Driver: presents characters in bursts, predicting each one on its transfer.
	always @(posedge clk or negedge arst_n) begin
		feed_t nxt;
		if (!arst_n) begin
			push       <= 1'b0;
			item       <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (push && !full) begin
				tokenize_char(item);
				chars_sent++;
				if (item.line_end) lines_sent++;
			end
			if (push && full) begin
				// Hold the current character until it is taken.
			end else if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (char_feed.size() != 0 &&
					(!char_feed[0].drain || expected_tokens.size() == 0)) begin
				nxt = char_feed.pop_front();
				push <= 1'b1;
				item <= nxt.it;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 48);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: takes results on a stall pattern of its own and checks each one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			cyc = 0;
			stall_left = 0;
		end else begin
			cyc++;
			if (pop && !empty) begin
				n_checked++;
				if (expected_tokens.size() == 0) begin
					report_fail($sformatf({"result with nothing expected: kind %0d type %0d ",
						"col %0d len %0d err %0d last %0d"},
						result.item_kind, result.token_type, result.start_column,
						result.token_length, result.error_code, result.is_last));
				end else begin
					want = expected_tokens.pop_front();
					if (result.item_kind !== want.item_kind ||
							result.token_type !== want.token_type ||
							result.start_column !== want.start_column ||
							result.token_length !== want.token_length ||
							result.error_code !== want.error_code ||
							result.is_last !== want.is_last)
						report_fail($sformatf({"mismatch: expected kind %0d type %0d col %0d ",
							"len %0d err %0d last %0d, got kind %0d type %0d col %0d len %0d ",
							"err %0d last %0d"},
							want.item_kind, want.token_type, want.start_column,
							want.token_length, want.error_code, want.is_last,
							result.item_kind, result.token_type, result.start_column,
							result.token_length, result.error_code, result.is_last));
				end
			end
			if (stall_left <= 0) begin
				stall_style = $urandom_range(0, 3);
				stall_left  = $urandom_range(20, 200);
			end else begin
				stall_left--;
			end
			case (stall_style)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= (cyc % 5 == 0);
				default: pop <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		reset_scanner();

		// Directed lines: quote joining a pending token, a hash inside a string,
		// extreme byte values, punctuation and an empty line.
		put_text("a=\"b c\"#\"");
		put_eol();
		put_text("\"q#");
		put_eol();
		put_item(8'hFF, 1'b0);
		put_item(8'h01, 1'b0);
		put_item(CH_TAB, 1'b0);
		put_item(CH_LPAR, 1'b0);
		put_eol();
		put_eol();

		while (stim_count < 850) make_line();

		// A long run of spaces, so that later tokens start at large columns.
		hold_next = 1;
		put_text("k9 ");
		for (int i = 0; i < 120; i++) put_item(CH_SPACE, 1'b0);
		put_text("zz(\"s t");
		put_eol();

		while (stim_count < 1700) make_line();

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (char_feed.size() != 0 || push) @(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d characters in %0d lines; checked %0d results.",
			chars_sent, lines_sent, n_checked);
		$display("Tokens %0d (strings %0d, unknown %0d, overlong %0d), line ends %0d.",
			n_tokens, n_strings, n_unknown, n_long, n_markers);
		$display("Mismatches %0d.", fail_count);
		if (fail_count == 0 && expected_tokens.size() == 0) begin
			$display("PASS line_tokenizer");
		end else begin
			$display("FAIL line_tokenizer");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#6000000;
		$display("FAIL line_tokenizer");
		$finish;
	end

endmodule
